@@ hdl/lcp_pkg.sv @@
`timescale 1ns / 1ps

package lcp_pkg;

    // Default width of the parsed values, the brightness and the hold time.
    localparam int VALUE_WIDTH_DEF = 16;

    // Width of the lamp level field of a result beat.
    localparam int LEVEL_W = 16;

    // Depth of the job queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Characters of the command language and of the status text.
    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_B  = 8'h42;
    localparam logic [7:0] CHAR_C  = 8'h43;
    localparam logic [7:0] CHAR_D  = 8'h44;
    localparam logic [7:0] CHAR_E  = 8'h45;
    localparam logic [7:0] CHAR_Z  = 8'h5A;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Power-on value of the brightness and of the hold time.
    localparam int SETTING_RESET = 10;

    // Fields of the status text, in the order they are sent.
    localparam logic [1:0] FIELD_MODE   = 2'd0;
    localparam logic [1:0] FIELD_BRIGHT = 2'd1;
    localparam logic [1:0] FIELD_HOLD   = 2'd2;
    localparam logic [1:0] FIELD_EN     = 2'd3;

    // Kind code of a result beat.
    typedef enum logic [1:0] {
        KIND_LAMP = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_SAVE = 2'd2
    } t_kind;

    // Kind of a job handed from the front to the back.
    typedef enum logic [1:0] {
        JOB_LAMP,
        JOB_STATUS,
        JOB_SAVE
    } t_job_kind;

    // Control part of a job. A status job also carries a snapshot of the
    // two single-bit settings; the wide settings travel beside it.
    typedef struct packed {
        t_job_kind            kind;
        logic                 last;
        logic                 mode;
        logic                 en;
        logic [LEVEL_W-1:0]   level;
    } t_job;

    // Front sequencer steps.
    typedef enum logic [2:0] {
        FE_EMPTY,
        FE_MAIN,
        FE_END,
        FE_SAVE,
        FE_TICK_OFF
    } t_fstate;

    // Back sequencer steps.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SMALL,
        BK_LETTER,
        BK_CONV,
        BK_DIGITS,
        BK_CR,
        BK_LF
    } t_bstate;

    // Number of decimal digits of the largest value of a given bit width.
    function automatic int dec_digits(input int width);
        longint unsigned vmax;
        longint unsigned p;
        int              n;
        vmax = (longint'(1) << width) - 1;
        p    = 10;
        n    = 1;
        for (int i = 0; i < 20; i++) begin
            if (p <= vmax) begin
                n = n + 1;
                p = p * 10;
            end
        end
        return n;
    endfunction

endpackage

@@ hdl/lamp_command_parser_controller.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake                   | Payload per beat
// ---------+-----------------------------+----------------------------------------------
// input    | i_in_valid / o_in_stall     | i_action, i_rx_byte, i_end_of_buffer,
//          |                             | i_light_signal, i_motion_seen
// output   | o_out_valid / i_out_stall   | o_kind, o_lamp_level, o_tx_char, o_last
//
// A digit, a plain byte or a tick runs a single step in the front sequencer, so such
// beats are taken back to back while the queue has room; a tick that starts a hold
// of zero length runs a lamp-on step and then a lamp-off step, and a byte that ends
// a buffer runs its command, the end of buffer and, if a setting changed, a save request.
// In the back, a status text runs a bit-serial binary-to-decimal conversion of the
// brightness and of the hold time.
// Reset (i_rst_n low at a clock edge) restores the power-on settings and empties
// the job queue and the output register.
// The front stalls its input while a later step of the current beat is still to run and
// while a job waits for room in the four-entry queue; the back stalls only on
// i_out_stall, and a result beat holds in the output register while the next input
// beat is taken.

module lamp_command_parser_controller #(
    parameter int VALUE_WIDTH = lcp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_end_of_buffer,
    input  logic                        i_light_signal,
    input  logic                        i_motion_seen,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_kind,
    output logic [lcp_pkg::LEVEL_W-1:0] o_lamp_level,
    output logic [7:0]                  o_tx_char,
    output logic                        o_last
);

    // Jobs from the front: lamp levels, status requests with a snapshot of
    // the settings, and save requests, each marked if it closes its beat.
    logic                   push;
    logic                   q_full;
    lcp_pkg::t_job          f_job;
    logic [VALUE_WIDTH-1:0] f_bright;
    logic [VALUE_WIDTH-1:0] f_hold;

    // Head of the queue as the back sees it.
    logic                   pop;
    logic                   q_empty;
    lcp_pkg::t_job          b_job;
    logic [VALUE_WIDTH-1:0] b_bright;
    logic [VALUE_WIDTH-1:0] b_hold;

    // The front parses bytes, runs commands against the settings and drives
    // the lamp on ticks. All state changes happen here, in item order.
    lcp_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_light_signal  (i_light_signal),
        .i_motion_seen   (i_motion_seen),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_job           (f_job),
        .o_job_bright    (f_bright),
        .o_job_hold      (f_hold)
    );

    // The queue decouples the two sides, so a long status text in the back
    // does not hold up parsing.
    lcp_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (f_job),
        .i_bright (f_bright),
        .i_hold   (f_hold),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_job    (b_job),
        .o_bright (b_bright),
        .o_hold   (b_hold),
        .o_empty  (q_empty)
    );

    // The back turns each job into result beats, expanding a status request
    // into its text with the values in decimal.
    lcp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (b_job),
        .i_job_bright (b_bright),
        .i_job_hold   (b_hold),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_lamp_level (o_lamp_level),
        .o_tx_char    (o_tx_char),
        .o_last       (o_last)
    );

endmodule

@@ hdl/lcp_front.sv @@
`timescale 1ns / 1ps

module lcp_front #(
    parameter int VALUE_WIDTH = lcp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_action,
    input  logic [7:0]             i_rx_byte,
    input  logic                   i_end_of_buffer,
    input  logic                   i_light_signal,
    input  logic                   i_motion_seen,
    input  logic                   i_q_full,
    output logic                   o_push,
    output lcp_pkg::t_job          o_job,
    output logic [VALUE_WIDTH-1:0] o_job_bright,
    output logic [VALUE_WIDTH-1:0] o_job_hold
);

    localparam int VW = VALUE_WIDTH;
    localparam int PW = VALUE_WIDTH + 4;
    localparam int LW = lcp_pkg::LEVEL_W;
    localparam logic [VW-1:0] VAL_ONE = VW'(1);
    localparam logic [VW-1:0] VAL_RESET = VW'(lcp_pkg::SETTING_RESET);

    lcp_pkg::t_fstate r_fstate, n_fstate;

    // Item held for the sequencer.
    logic          r_action;
    logic [7:0]    r_byte;
    logic          r_end;
    logic          r_light;
    logic          r_motion;

    // Settings and parser state.
    logic          r_mode, n_mode;
    logic [VW-1:0] r_bright, n_bright;
    logic [VW-1:0] r_hold_time, n_hold_time;
    logic          r_en, n_en;
    logic          r_holding, n_holding;
    logic [VW-1:0] r_hold_left, n_hold_left;
    logic [7:0]    r_letter, n_letter;
    logic          r_pend, n_pend;
    logic [VW-1:0] r_val, n_val;
    logic          r_touched, n_touched;

    logic          acc;
    logic          item_done;
    logic          is_digit;
    logic          is_letter;
    logic [PW-1:0] prod;
    logic [VW-1:0] val_next;
    logic          run;
    logic          c_a, c_b, c_c, c_d, c_e;
    logic          cmd_set;
    logic          cmd_job;
    logic          mode1, en1, holding1, touched1;
    logic [VW-1:0] bright1, hold1;
    logic          pend1;
    logic [7:0]    letter1;
    logic [VW-1:0] val1;
    logic          look_job;
    logic          touched2;
    logic [VW-1:0] hold_dec;
    logic          start;
    logic          step_need;
    logic          step_adv;
    lcp_pkg::t_fstate step_next;

    // Command decode and its effect on the settings, shared by the step that
    // runs a command on a non-digit byte and the step that runs it at the end
    // of a buffer.
    always_comb begin
        is_digit  = (r_byte >= lcp_pkg::CHAR_0) && (r_byte <= lcp_pkg::CHAR_9);
        is_letter = (r_byte >= lcp_pkg::CHAR_A) && (r_byte <= lcp_pkg::CHAR_Z);
        prod      = (PW'(r_val) << 3) + (PW'(r_val) << 1) + PW'(r_byte[3:0]);
        val_next  = (prod[PW-1:VW] != '0) ? '1 : prod[VW-1:0];

        run = r_pend && (((r_fstate == lcp_pkg::FE_MAIN) && !r_action && !is_digit) ||
                         (r_fstate == lcp_pkg::FE_END));
        c_a = (r_letter == lcp_pkg::CHAR_A);
        c_b = (r_letter == lcp_pkg::CHAR_B);
        c_c = (r_letter == lcp_pkg::CHAR_C);
        c_d = (r_letter == lcp_pkg::CHAR_D);
        c_e = (r_letter == lcp_pkg::CHAR_E);
        cmd_set  = run && (c_a || c_b || c_c || c_d);
        cmd_job  = run && (c_e || (c_d && (r_val != VAL_ONE) && r_holding));
        mode1    = (run && c_a) ? (r_val != '0) : r_mode;
        bright1  = (run && c_b) ? r_val : r_bright;
        hold1    = (run && c_c) ? r_val : r_hold_time;
        en1      = (run && c_d) ? (r_val == VAL_ONE) : r_en;
        holding1 = (run && c_d && (r_val != VAL_ONE)) ? 1'b0 : r_holding;
        touched1 = r_touched || cmd_set;

        // What the end-of-buffer step will find after this byte.
        pend1    = is_digit ? r_pend : is_letter;
        letter1  = is_letter ? r_byte : r_letter;
        val1     = is_digit ? (r_pend ? val_next : r_val) : '0;
        look_job = pend1 && ((letter1 == lcp_pkg::CHAR_E) ||
                             ((letter1 == lcp_pkg::CHAR_D) && (val1 != VAL_ONE) && holding1));
        touched2 = touched1 || (pend1 && (letter1 >= lcp_pkg::CHAR_A) &&
                                (letter1 <= lcp_pkg::CHAR_D));

        hold_dec = (r_holding && (r_hold_left != '0)) ? r_hold_left - VW'(1) : r_hold_left;
        start    = r_motion && !r_holding;
    end

    // Step datapath: the job of this step and the state it leaves.
    always_comb begin
        n_mode      = r_mode;
        n_bright    = r_bright;
        n_hold_time = r_hold_time;
        n_en        = r_en;
        n_holding   = r_holding;
        n_hold_left = r_hold_left;
        n_letter    = r_letter;
        n_pend      = r_pend;
        n_val       = r_val;
        n_touched   = r_touched;

        o_job.kind   = lcp_pkg::JOB_LAMP;
        o_job.last   = 1'b1;
        o_job.mode   = r_mode;
        o_job.en     = r_en;
        o_job.level  = '0;
        o_job_bright = r_bright;
        o_job_hold   = r_hold_time;
        step_need    = 1'b0;
        step_next    = lcp_pkg::FE_EMPTY;

        unique case (r_fstate)
            lcp_pkg::FE_EMPTY: begin
            end
            lcp_pkg::FE_MAIN: begin
                if (!r_action) begin
                    step_need   = cmd_job;
                    o_job.kind  = c_e ? lcp_pkg::JOB_STATUS : lcp_pkg::JOB_LAMP;
                    o_job.last  = !(r_end && (look_job || touched2));
                    n_mode      = mode1;
                    n_bright    = bright1;
                    n_hold_time = hold1;
                    n_en        = en1;
                    n_holding   = holding1;
                    n_touched   = touched1;
                    if (is_digit) begin
                        if (r_pend) begin
                            n_val = val_next;
                        end
                    end else if (is_letter) begin
                        n_letter = r_byte;
                        n_pend   = 1'b1;
                        n_val    = '0;
                    end else begin
                        n_pend = 1'b0;
                    end
                    step_next = r_end ? lcp_pkg::FE_END : lcp_pkg::FE_EMPTY;
                end else begin
                    n_hold_left = hold_dec;
                    if (!r_en) begin
                        step_need = 1'b1;
                    end else if (!r_mode) begin
                        step_need   = 1'b1;
                        o_job.level = r_light ? LW'(r_bright) : '0;
                    end else if (start) begin
                        step_need   = 1'b1;
                        o_job.level = LW'(r_bright);
                        n_hold_left = r_hold_time;
                        n_holding   = 1'b1;
                        if (r_hold_time == '0) begin
                            o_job.last = 1'b0;
                            step_next  = lcp_pkg::FE_TICK_OFF;
                        end
                    end else if (r_holding && (hold_dec == '0)) begin
                        step_need = 1'b1;
                        n_holding = 1'b0;
                    end
                end
            end
            lcp_pkg::FE_END: begin
                step_need   = cmd_job;
                o_job.kind  = c_e ? lcp_pkg::JOB_STATUS : lcp_pkg::JOB_LAMP;
                o_job.last  = !touched1;
                n_mode      = mode1;
                n_bright    = bright1;
                n_hold_time = hold1;
                n_en        = en1;
                n_holding   = holding1;
                n_touched   = touched1;
                n_pend      = 1'b0;
                n_val       = '0;
                step_next   = touched1 ? lcp_pkg::FE_SAVE : lcp_pkg::FE_EMPTY;
            end
            lcp_pkg::FE_SAVE: begin
                step_need  = 1'b1;
                o_job.kind = lcp_pkg::JOB_SAVE;
                n_touched  = 1'b0;
            end
            lcp_pkg::FE_TICK_OFF: begin
                step_need = 1'b1;
                n_holding = 1'b0;
            end
            default: begin
            end
        endcase

        step_adv = !step_need || !i_q_full;
    end

    // Handshake outputs.
    always_comb begin
        item_done  = (r_fstate == lcp_pkg::FE_EMPTY) ||
                     (step_adv && (step_next == lcp_pkg::FE_EMPTY));
        o_in_stall = !item_done;
        acc        = i_in_valid && item_done;
        o_push     = step_need && step_adv;
    end

    // Next step.
    always_comb begin
        n_fstate = r_fstate;
        if (item_done) begin
            n_fstate = acc ? lcp_pkg::FE_MAIN : lcp_pkg::FE_EMPTY;
        end else if (step_adv) begin
            n_fstate = step_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate    <= lcp_pkg::FE_EMPTY;
            r_mode      <= 1'b0;
            r_bright    <= VAL_RESET;
            r_hold_time <= VAL_RESET;
            r_en        <= 1'b1;
            r_holding   <= 1'b0;
            r_hold_left <= '0;
            r_letter    <= '0;
            r_pend      <= 1'b0;
            r_val       <= '0;
            r_touched   <= 1'b0;
        end else begin
            r_fstate <= n_fstate;
            if (step_adv) begin
                r_mode      <= n_mode;
                r_bright    <= n_bright;
                r_hold_time <= n_hold_time;
                r_en        <= n_en;
                r_holding   <= n_holding;
                r_hold_left <= n_hold_left;
                r_letter    <= n_letter;
                r_pend      <= n_pend;
                r_val       <= n_val;
                r_touched   <= n_touched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_action <= i_action;
            r_byte   <= i_rx_byte;
            r_end    <= i_end_of_buffer;
            r_light  <= i_light_signal;
            r_motion <= i_motion_seen;
        end
    end

    // The second beat of a zero-length hold only follows a hold that started
    // with nothing left to count.
    a_tick_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fstate == lcp_pkg::FE_TICK_OFF) |-> (r_holding && (r_hold_left == '0)))
        else $error("second tick beat without an expired hold");

    // A save step is only entered with changed settings.
    a_save_touched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fstate == lcp_pkg::FE_SAVE) |-> r_touched)
        else $error("save step entered with no changed setting");

endmodule

@@ hdl/lcp_queue.sv @@
`timescale 1ns / 1ps

module lcp_queue #(
    parameter int VALUE_WIDTH = lcp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  lcp_pkg::t_job          i_job,
    input  logic [VALUE_WIDTH-1:0] i_bright,
    input  logic [VALUE_WIDTH-1:0] i_hold,
    output logic                   o_full,
    input  logic                   i_pop,
    output lcp_pkg::t_job          o_job,
    output logic [VALUE_WIDTH-1:0] o_bright,
    output logic [VALUE_WIDTH-1:0] o_hold,
    output logic                   o_empty
);

    localparam int PW = lcp_pkg::QPTR_W;
    localparam int CW = lcp_pkg::QCNT_W;

    lcp_pkg::t_job          r_job    [lcp_pkg::QDEPTH];
    logic [VALUE_WIDTH-1:0] r_bright [lcp_pkg::QDEPTH];
    logic [VALUE_WIDTH-1:0] r_hold   [lcp_pkg::QDEPTH];
    logic [PW-1:0]          r_wr, n_wr;
    logic [PW-1:0]          r_rd, n_rd;
    logic [CW-1:0]          r_cnt, n_cnt;

    always_comb begin
        o_full   = (r_cnt == CW'(lcp_pkg::QDEPTH));
        o_empty  = (r_cnt == '0);
        o_job    = r_job[r_rd];
        o_bright = r_bright[r_rd];
        o_hold   = r_hold[r_rd];
        n_wr     = i_push ? r_wr + PW'(1) : r_wr;
        n_rd     = i_pop ? r_rd + PW'(1) : r_rd;
        n_cnt    = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[r_wr]    <= i_job;
            r_bright[r_wr] <= i_bright;
            r_hold[r_wr]   <= i_hold;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from an empty queue");

endmodule

@@ hdl/lcp_back.sv @@
`timescale 1ns / 1ps

module lcp_back #(
    parameter int VALUE_WIDTH = lcp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  lcp_pkg::t_job                i_job,
    input  logic [VALUE_WIDTH-1:0]       i_job_bright,
    input  logic [VALUE_WIDTH-1:0]       i_job_hold,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_kind,
    output logic [lcp_pkg::LEVEL_W-1:0]  o_lamp_level,
    output logic [7:0]                   o_tx_char,
    output logic                         o_last
);

    localparam int VW    = VALUE_WIDTH;
    localparam int LW    = lcp_pkg::LEVEL_W;
    localparam int ND    = lcp_pkg::dec_digits(VALUE_WIDTH);
    localparam int BCD_W = 4 * ND;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    lcp_pkg::t_bstate r_bstate, n_bstate;

    logic [1:0]       r_field, n_field;
    logic             r_mode, n_mode;
    logic             r_en, n_en;
    logic [VW-1:0]    r_bright, n_bright;
    logic [VW-1:0]    r_hold, n_hold;
    logic             r_last, n_last;
    logic [VW-1:0]    r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_lead, n_lead;

    logic             r_ov;
    lcp_pkg::t_kind   r_okind;
    logic [LW-1:0]    r_olevel;
    logic [7:0]       r_ochar;
    logic             r_olast;

    logic             can_load;
    logic [3:0]       bcd_top;
    logic             skip;
    logic [BCD_W-1:0] bcd_adj;
    logic             beat;
    lcp_pkg::t_kind   b_kind;
    logic [LW-1:0]    b_level;
    logic [7:0]       b_char;
    logic             b_last;

    always_comb begin
        can_load = !r_ov || !i_out_stall;
        bcd_top  = r_bcd[BCD_W-1 -: 4];
        skip     = r_lead && (bcd_top == 4'd0) && (r_cnt != '0);
        for (int i = 0; i < ND; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    // Next step.
    always_comb begin
        n_bstate = r_bstate;
        unique case (r_bstate)
            lcp_pkg::BK_IDLE: begin
                if (!i_q_empty && can_load && (i_job.kind == lcp_pkg::JOB_STATUS)) begin
                    n_bstate = lcp_pkg::BK_SMALL;
                end
            end
            lcp_pkg::BK_SMALL: begin
                if (can_load) begin
                    n_bstate = (r_field == lcp_pkg::FIELD_MODE) ? lcp_pkg::BK_LETTER
                                                                : lcp_pkg::BK_CR;
                end
            end
            lcp_pkg::BK_LETTER: begin
                if (can_load) begin
                    n_bstate = (r_field == lcp_pkg::FIELD_EN) ? lcp_pkg::BK_SMALL
                                                              : lcp_pkg::BK_CONV;
                end
            end
            lcp_pkg::BK_CONV: begin
                if (r_cnt == CNT_W'(VW - 1)) begin
                    n_bstate = lcp_pkg::BK_DIGITS;
                end
            end
            lcp_pkg::BK_DIGITS: begin
                if (!skip && can_load && (r_cnt == '0)) begin
                    n_bstate = lcp_pkg::BK_LETTER;
                end
            end
            lcp_pkg::BK_CR: begin
                if (can_load) begin
                    n_bstate = lcp_pkg::BK_LF;
                end
            end
            lcp_pkg::BK_LF: begin
                if (can_load) begin
                    n_bstate = lcp_pkg::BK_IDLE;
                end
            end
            default: begin
                n_bstate = lcp_pkg::BK_IDLE;
            end
        endcase
    end

    // Beats, queue pops and the conversion datapath.
    always_comb begin
        n_field  = r_field;
        n_mode   = r_mode;
        n_en     = r_en;
        n_bright = r_bright;
        n_hold   = r_hold;
        n_last   = r_last;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_lead   = r_lead;
        o_pop    = 1'b0;
        beat     = 1'b0;
        b_kind   = lcp_pkg::KIND_CHAR;
        b_level  = '0;
        b_char   = '0;
        b_last   = 1'b0;

        unique case (r_bstate)
            lcp_pkg::BK_IDLE: begin
                if (!i_q_empty && can_load) begin
                    o_pop = 1'b1;
                    beat  = 1'b1;
                    unique case (i_job.kind)
                        lcp_pkg::JOB_LAMP: begin
                            b_kind  = lcp_pkg::KIND_LAMP;
                            b_level = i_job.level;
                            b_last  = i_job.last;
                        end
                        lcp_pkg::JOB_SAVE: begin
                            b_kind = lcp_pkg::KIND_SAVE;
                            b_last = i_job.last;
                        end
                        lcp_pkg::JOB_STATUS: begin
                            b_char   = lcp_pkg::CHAR_A;
                            n_field  = lcp_pkg::FIELD_MODE;
                            n_mode   = i_job.mode;
                            n_en     = i_job.en;
                            n_bright = i_job_bright;
                            n_hold   = i_job_hold;
                            n_last   = i_job.last;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lcp_pkg::BK_SMALL: begin
                if (can_load) begin
                    beat = 1'b1;
                    if (r_field == lcp_pkg::FIELD_MODE) begin
                        b_char  = lcp_pkg::CHAR_0 + {7'd0, r_mode};
                        n_field = lcp_pkg::FIELD_BRIGHT;
                    end else begin
                        b_char = lcp_pkg::CHAR_0 + {7'd0, r_en};
                    end
                end
            end
            lcp_pkg::BK_LETTER: begin
                if (can_load) begin
                    beat   = 1'b1;
                    b_char = lcp_pkg::CHAR_A + {6'd0, r_field};
                    n_bin  = (r_field == lcp_pkg::FIELD_BRIGHT) ? r_bright : r_hold;
                    n_bcd  = '0;
                    n_cnt  = '0;
                end
            end
            lcp_pkg::BK_CONV: begin
                // One shift-and-add-three step per cycle, most significant
                // bit first.
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[VW-1]};
                n_bin = r_bin << 1;
                if (r_cnt == CNT_W'(VW - 1)) begin
                    n_cnt  = CNT_W'(ND - 1);
                    n_lead = 1'b1;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            lcp_pkg::BK_DIGITS: begin
                if (skip) begin
                    n_bcd = r_bcd << 4;
                    n_cnt = r_cnt - CNT_W'(1);
                end else if (can_load) begin
                    beat   = 1'b1;
                    b_char = lcp_pkg::CHAR_0 + {4'd0, bcd_top};
                    n_bcd  = r_bcd << 4;
                    n_lead = 1'b0;
                    if (r_cnt == '0) begin
                        n_field = r_field + 2'd1;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            lcp_pkg::BK_CR: begin
                if (can_load) begin
                    beat   = 1'b1;
                    b_char = lcp_pkg::CHAR_CR;
                end
            end
            lcp_pkg::BK_LF: begin
                if (can_load) begin
                    beat   = 1'b1;
                    b_char = lcp_pkg::CHAR_LF;
                    b_last = r_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= lcp_pkg::BK_IDLE;
            r_ov     <= 1'b0;
        end else begin
            r_bstate <= n_bstate;
            if (beat) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_field  <= n_field;
        r_mode   <= n_mode;
        r_en     <= n_en;
        r_bright <= n_bright;
        r_hold   <= n_hold;
        r_last   <= n_last;
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_cnt    <= n_cnt;
        r_lead   <= n_lead;
        if (beat) begin
            r_okind  <= b_kind;
            r_olevel <= b_level;
            r_ochar  <= b_char;
            r_olast  <= b_last;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_kind       = r_okind;
    assign o_lamp_level = r_olevel;
    assign o_tx_char    = r_ochar;
    assign o_last       = r_olast;

    // A conversion runs to its end and hands over straight to the digits.
    a_conv_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bstate == lcp_pkg::BK_CONV) |=>
            ((r_bstate == lcp_pkg::BK_CONV) || (r_bstate == lcp_pkg::BK_DIGITS)))
        else $error("conversion left before its last step");

endmodule

@@ tb/lamp_command_parser_controller_tb.sv @@
`timescale 1ns / 1ps

module lamp_command_parser_controller_tb;

    // A sender task offers one beat at a time on the input channel, with gaps
    // of random length in between. A monitor predicts the result beats of every
    // accepted input beat into a queue. A checker compares each accepted result
    // beat with the oldest prediction. The output stall is driven by a process
    // of its own: random stretches, plus one long hold-off on request.

    // Code of the action field.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam int VW = lcp_pkg::VALUE_WIDTH_DEF;
    localparam logic [VW-1:0] VALUE_MAX = '1;

    // Number of random input beats after the directed part.
    localparam int RANDOM_BEATS = 140;

    // Cycles of quiet time after the last prediction is met.
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        lcp_pkg::t_kind kind;
        logic [15:0]    level;
        logic [7:0]     ch;
        logic           last;
    } t_lamp_beat;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          in_valid;
    logic                          o_in_stall;
    logic                          in_action;
    logic [7:0]                    in_rx_byte;
    logic                          in_eob;
    logic                          in_light;
    logic                          in_motion;
    logic                          o_out_valid;
    logic                          out_stall;
    logic [1:0]                    o_kind;
    logic [lcp_pkg::LEVEL_W-1:0]   o_lamp_level;
    logic [7:0]                    o_tx_char;
    logic                          o_last;

    lamp_command_parser_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (in_action),
        .i_rx_byte       (in_rx_byte),
        .i_end_of_buffer (in_eob),
        .i_light_signal  (in_light),
        .i_motion_seen   (in_motion),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (o_kind),
        .o_lamp_level    (o_lamp_level),
        .o_tx_char       (o_tx_char),
        .o_last          (o_last)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Expected result beats, oldest first.
    t_lamp_beat expected_beats[$];

    int errors        = 0;
    int items_sent    = 0;
    int beats_checked = 0;

    // Set by a test to ask for a long output hold-off, in cycles.
    int hold_off_left = 0;
    // While set, neither side idles.
    bit no_idle       = 1'b0;

    // Predicted state of the lamp controller and of its command parser.
    logic          pred_mode;
    logic [VW-1:0] pred_bright;
    logic [VW-1:0] pred_hold_time;
    logic          pred_enabled;
    logic          pred_holding;
    logic [VW-1:0] pred_hold_left;
    logic [7:0]    pred_letter;
    logic          pred_letter_valid;
    logic [VW-1:0] pred_value;
    logic          pred_dirty;

    function automatic logic coin();
        coin = ($urandom_range(0, 1) != 0);
    endfunction

    function automatic logic [7:0] rand_byte();
        rand_byte = 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic push_beat(input lcp_pkg::t_kind k, input logic [15:0] lvl,
                             input logic [7:0] ch);
        t_lamp_beat b;
        b.kind  = k;
        b.level = lvl;
        b.ch    = ch;
        b.last  = 1'b0;
        expected_beats.push_back(b);
    endtask

    task automatic push_decimal(input longint unsigned v);
        string s;
        s = $sformatf("%0d", v);
        foreach (s[i])
            push_beat(lcp_pkg::KIND_CHAR, '0, s[i]);
    endtask

    // Carries out a finished command: a letter with its parsed value.
    task automatic run_lamp_command(input logic [7:0] letter, input logic [VW-1:0] val);
        unique case (letter)
            lcp_pkg::CHAR_A: begin
                pred_mode  = (val != 0);
                pred_dirty = 1'b1;
            end
            lcp_pkg::CHAR_B: begin
                pred_bright = val;
                pred_dirty  = 1'b1;
            end
            lcp_pkg::CHAR_C: begin
                pred_hold_time = val;
                pred_dirty     = 1'b1;
            end
            lcp_pkg::CHAR_D: begin
                pred_enabled = (val == 1);
                // Switching off during a hold ends the hold at once.
                if (!pred_enabled && pred_holding) begin
                    pred_holding = 1'b0;
                    push_beat(lcp_pkg::KIND_LAMP, '0, '0);
                end
                pred_dirty = 1'b1;
            end
            lcp_pkg::CHAR_E: begin
                push_beat(lcp_pkg::KIND_CHAR, '0, lcp_pkg::CHAR_A);
                push_decimal(longint'(pred_mode));
                push_beat(lcp_pkg::KIND_CHAR, '0, lcp_pkg::CHAR_B);
                push_decimal(longint'(pred_bright));
                push_beat(lcp_pkg::KIND_CHAR, '0, lcp_pkg::CHAR_C);
                push_decimal(longint'(pred_hold_time));
                push_beat(lcp_pkg::KIND_CHAR, '0, lcp_pkg::CHAR_D);
                push_decimal(longint'(pred_enabled));
                push_beat(lcp_pkg::KIND_CHAR, '0, lcp_pkg::CHAR_CR);
                push_beat(lcp_pkg::KIND_CHAR, '0, lcp_pkg::CHAR_LF);
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_lamp_beat(input logic act, input logic [7:0] rx, input logic eob,
                                     input logic light, input logic motion);
        int              n0;
        longint unsigned acc;
        n0 = expected_beats.size();
        if (act == ACT_BYTE) begin
            if (rx >= lcp_pkg::CHAR_0 && rx <= lcp_pkg::CHAR_9) begin
                // Digits only count after a letter; the value saturates.
                if (pred_letter_valid) begin
                    acc = longint'(pred_value) * 10 + longint'(rx - lcp_pkg::CHAR_0);
                    pred_value = (acc > longint'(VALUE_MAX)) ? VALUE_MAX : acc[VW-1:0];
                end
            end else begin
                if (pred_letter_valid) begin
                    pred_letter_valid = 1'b0;
                    run_lamp_command(pred_letter, pred_value);
                end
                if (rx >= lcp_pkg::CHAR_A && rx <= lcp_pkg::CHAR_Z) begin
                    pred_letter       = rx;
                    pred_letter_valid = 1'b1;
                    pred_value        = '0;
                end
            end
            if (eob) begin
                if (pred_letter_valid) begin
                    pred_letter_valid = 1'b0;
                    run_lamp_command(pred_letter, pred_value);
                end
                pred_value = '0;
                if (pred_dirty) begin
                    pred_dirty = 1'b0;
                    push_beat(lcp_pkg::KIND_SAVE, '0, '0);
                end
            end
        end else begin
            // A running hold counts down on every tick, whatever the mode.
            if (pred_holding && pred_hold_left != 0)
                pred_hold_left = pred_hold_left - VW'(1);
            if (!pred_enabled) begin
                push_beat(lcp_pkg::KIND_LAMP, '0, '0);
            end else if (!pred_mode) begin
                push_beat(lcp_pkg::KIND_LAMP, light ? pred_bright : '0, '0);
            end else begin
                if (motion && !pred_holding) begin
                    push_beat(lcp_pkg::KIND_LAMP, pred_bright, '0);
                    pred_hold_left = pred_hold_time;
                    pred_holding   = 1'b1;
                end
                if (pred_holding && pred_hold_left == 0) begin
                    push_beat(lcp_pkg::KIND_LAMP, '0, '0);
                    pred_holding = 1'b0;
                end
            end
        end
        if (expected_beats.size() > n0)
            expected_beats[expected_beats.size() - 1].last = 1'b1;
    endtask

    // Every accepted input beat is predicted here, at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall)
            predict_lamp_beat(in_action, in_rx_byte, in_eob, in_light, in_motion);
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_lamp_beat want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d level %0d char %02h last %0b",
                                          o_kind, o_lamp_level, o_tx_char, o_last));
            end else begin
                want = expected_beats.pop_front();
                if (o_kind !== want.kind || o_lamp_level !== want.level ||
                    o_tx_char !== want.ch || o_last !== want.last)
                    report_mismatch($sformatf(
                        "beat %0d: got kind %0d level %0d char %02h last %0b, want %0d %0d %02h %0b",
                        beats_checked, o_kind, o_lamp_level, o_tx_char, o_last,
                        want.kind, want.level, want.ch, want.last));
            end
            beats_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Output stall: random stretches, mostly short; a long hold-off when a
    // test asks for one. The hold-off is counted here, cycle by cycle.
    // ------------------------------------------------------------------

    initial begin
        int stall_run_left;
        int r;
        out_stall      = 1'b0;
        stall_run_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                out_stall = 1'b1;
                hold_off_left--;
            end else if (no_idle) begin
                out_stall = 1'b0;
            end else if (stall_run_left > 0) begin
                stall_run_left--;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    out_stall      = 1'b0;
                    stall_run_left = $urandom_range(0, 30);
                end else if (r < 9) begin
                    out_stall      = 1'b1;
                    stall_run_left = $urandom_range(0, 2);
                end else begin
                    out_stall      = 1'b1;
                    stall_run_left = $urandom_range(9, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one input beat after a random gap and returns at the edge that
    // takes it. Valid stays high afterwards; the next call either changes
    // the payload at the next falling edge or opens a gap there.
    task automatic send_beat(input logic act, input logic [7:0] rx, input logic eob,
                             input logic light, input logic motion);
        int gap;
        int r;
        r = $urandom_range(0, 9);
        if (no_idle || r < 6)
            gap = 0;
        else if (r < 9)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   = 1'b1;
        in_action  = act;
        in_rx_byte = rx;
        in_eob     = eob;
        in_light   = light;
        in_motion  = motion;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Sends a string as command bytes; the unused tick fields are random.
    task automatic send_text(input string s, input logic eob_on_last);
        foreach (s[i])
            send_beat(ACT_BYTE, s[i], eob_on_last && (i == s.len() - 1), coin(), coin());
    endtask

    // Sends a tick; the unused byte fields are random.
    task automatic send_tick(input logic light, input logic motion);
        send_beat(ACT_TICK, rand_byte(), coin(), light, motion);
    endtask

    // Drops valid and waits until every predicted beat has come out.
    task automatic wait_for_results();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic longint unsigned pick_setting_value(input logic [7:0] letter);
        int r;
        r = $urandom_range(0, 9);
        if (letter == lcp_pkg::CHAR_A || letter == lcp_pkg::CHAR_D)
            return (r < 8) ? $urandom_range(0, 1) : $urandom_range(0, 99);
        // Hold times stay short mostly, so that holds end within the run.
        if (letter == lcp_pkg::CHAR_C && r < 8)
            return $urandom_range(0, 6);
        if (r < 6)
            return $urandom_range(0, 300);
        if (r < 9)
            return $urandom_range(0, 65535);
        return $urandom_range(65536, 9999999);
    endfunction

    // One buffer of one to three commands with random values and
    // separators, the last byte flagged as end of buffer. Now and then a
    // stray byte spoils the tail.
    task automatic send_random_buffer();
        logic [7:0]      cmd_bytes[$];
        int              n_cmds;
        int              r;
        logic [7:0]      letter;
        logic [7:0]      b;
        string           digits;
        n_cmds = $urandom_range(1, 3);
        for (int c = 0; c < n_cmds; c++) begin
            r = $urandom_range(0, 15);
            if (r < 3)
                letter = lcp_pkg::CHAR_A;
            else if (r < 6)
                letter = lcp_pkg::CHAR_B;
            else if (r < 9)
                letter = lcp_pkg::CHAR_C;
            else if (r < 12)
                letter = lcp_pkg::CHAR_D;
            else if (r < 14)
                letter = lcp_pkg::CHAR_E;
            else
                letter = lcp_pkg::CHAR_E + 8'd1 + 8'($urandom_range(0, 20));
            cmd_bytes.push_back(letter);
            if ($urandom_range(0, 7) != 0) begin
                if ($urandom_range(0, 5) == 0)
                    cmd_bytes.push_back(lcp_pkg::CHAR_0);
                digits = $sformatf("%0d", pick_setting_value(letter));
                foreach (digits[i])
                    cmd_bytes.push_back(digits[i]);
            end
            r = $urandom_range(0, 5);
            if (r == 1)
                cmd_bytes.push_back(8'h20);
            else if (r == 2)
                cmd_bytes.push_back(8'h2C);
            else if (r == 3)
                cmd_bytes.push_back(8'h00);
            else if (r == 4) begin
                b = rand_byte();
                if (b >= lcp_pkg::CHAR_0 && b <= lcp_pkg::CHAR_9)
                    b = b ^ 8'h40;
                cmd_bytes.push_back(b);
            end
        end
        if ($urandom_range(0, 9) == 0)
            cmd_bytes.push_back(rand_byte());
        foreach (cmd_bytes[i])
            send_beat(ACT_BYTE, cmd_bytes[i], i == cmd_bytes.size() - 1, coin(), coin());
    endtask

    // One random group of beats: mostly well-formed buffers and ticks, some noise.
    task automatic send_random_beat_group();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            send_random_buffer();
        else if (r < 9)
            send_tick(coin(), coin());
        else
            send_beat(ACT_BYTE, rand_byte(), $urandom_range(0, 3) == 0, coin(), coin());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_commands();
        // Status text at the power-on settings; nothing changed, no save.
        send_text("E", 1'b1);
        // Automatic mode follows the light sensor.
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        // A stray digit with no letter is ignored.
        send_text("7", 1'b0);
        // A value past the top saturates.
        send_text("B99999", 1'b1);
        // An unused letter is parsed and dropped; a NUL ends it.
        send_text("Z", 1'b0);
        send_beat(ACT_BYTE, 8'h00, 1'b0, 1'b1, 1'b1);
        // Motion mode with a zero hold: on and off in the same tick.
        send_text("A1C0", 1'b1);
        send_tick(1'b0, 1'b1);
        // Motion mode and no motion: nothing to do, no result.
        send_tick(1'b1, 1'b0);
        // Start a hold, then switch the lamp off while it runs.
        send_text("C2", 1'b1);
        send_tick(1'b0, 1'b1);
        send_text("D0", 1'b1);
        // Disabled: every tick drives the lamp to zero.
        send_tick(1'b1, 1'b1);
        // Enable and read back in one buffer.
        send_beat(ACT_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_text("D1E", 1'b1);
        wait_for_results();
    endtask

    // The receiver holds off for a long time while the sender keeps going,
    // so the job queue fills up and the input must stall.
    task automatic test_hold_off_pressure();
        wait_for_results();
        @(posedge i_clk);
        hold_off_left = 300;
        send_text("A0B200E", 1'b1);
        for (int i = 0; i < 40; i++)
            send_tick(coin(), coin());
        wait_for_results();
    endtask

    // A stretch with no gaps and no output stalls.
    task automatic test_unbroken_stream();
        @(posedge i_clk);
        no_idle = 1'b1;
        for (int i = 0; i < 10; i++)
            send_random_beat_group();
        wait_for_results();
        @(posedge i_clk);
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_BEATS)
            send_random_beat_group();
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_action  = ACT_BYTE;
        in_rx_byte = '0;
        in_eob     = 1'b0;
        in_light   = 1'b0;
        in_motion  = 1'b0;

        // Predicted state after reset.
        pred_mode         = 1'b0;
        pred_bright       = VW'(lcp_pkg::SETTING_RESET);
        pred_hold_time    = VW'(lcp_pkg::SETTING_RESET);
        pred_enabled      = 1'b1;
        pred_holding      = 1'b0;
        pred_hold_left    = '0;
        pred_letter       = '0;
        pred_letter_valid = 1'b0;
        pred_value        = '0;
        pred_dirty        = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_commands();
        test_hold_off_pressure();
        test_unbroken_stream();
        test_random_traffic();

        // Let anything left in flight come out before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));

        if (errors == 0) begin
            $display("** lamp_command_parser_controller: PASSED **");
        end else begin
            $display("** lamp_command_parser_controller: FAILED **");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("** lamp_command_parser_controller: FAILED **");
        $finish;
    end

endmodule
